[sv/prl_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, register indexes and constants for the packet rate limiter.
// No dependencies; imported by every other file of the block.
package prl_pkg;

  localparam int SEC_W        = 32;
  localparam int USEC_W       = 20;
  localparam int CFG_W        = 20;
  localparam int CNT_W        = 32;
  localparam int HOLD_W       = 29;
  localparam int CFG_ADDR_W   = 1;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_TDATA_W  = 8;
  localparam int STEPS        = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_RATE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP  = 1'b1;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [8:0]        HOLD_SECONDS = 9'd360;
  localparam logic [CFG_W-1:0]  RESET_RATE   = 20'd1;
  localparam logic [CFG_W-1:0]  RESET_GAP    = 20'd1000000;

endpackage

[sv/packet_rate_limiter.sv]
`timescale 1ns / 1ps
// Channel    Dir  Word contents (lowest bit first)
// s_axis     in   now_sec[31:0], now_usec[51:32], upstream_ready[52], zero pad
// m_axis     out  pull_granted[0], packet_passed[1], zero pad
// cfg        in   cfg_addr 0 = rate, 1 = gap_usec; written when cfg_we is high
//
// A request goes through setup, the bit-serial multiply/divide of prl_muldiv
// and an update to its result load; the first after reset records the start
// time only. One request is in work at a time; a loaded result waits in the
// output register while the next word is accepted. Reset is synchronous.
// Depends on prl_pkg and prl_muldiv.
module packet_rate_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_sec[31:0], now_usec[51:32], upstream_ready[52], zeros above
  input  logic [prl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pull_granted[0], packet_passed[1], zeros above
  output logic [prl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [prl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [prl_pkg::CFG_W-1:0]       cfg_wdata
);
  import prl_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state;
  logic [CFG_W-1:0]  rate;
  logic [CFG_W-1:0]  gap_usec;
  logic [HOLD_W-1:0] hold_limit;
  logic              started;
  logic [SEC_W-1:0]  start_sec;
  logic [USEC_W-1:0] start_usec;
  logic [CNT_W-1:0]  granted_total;

  logic [SEC_W-1:0]  now_sec;
  logic [USEC_W-1:0] now_usec;
  logic              upstream_ready;
  logic              granted;

  logic [SEC_W-1:0]  dsec;
  logic [USEC_W-1:0] du;
  logic [CFG_W-1:0]  divisor;
  logic              md_start;
  logic              md_done;
  logic [CNT_W-1:0]  product;
  logic [USEC_W-1:0] quotient;

  logic [USEC_W:0]   du_raw;
  logic [USEC_W:0]   du_adj;
  logic [CNT_W-1:0]  need;
  logic [HOLD_W+8:0] hold_full;

  always_comb begin
    du_raw = {1'b0, now_usec} - {1'b0, start_usec};
    du_adj = du_raw + {1'b0, USEC_PER_SEC};
    if (!du_raw[USEC_W]) begin
      du = du_raw[USEC_W-1:0];
    end else if (du_adj[USEC_W]) begin
      du = '0;
    end else begin
      du = du_adj[USEC_W-1:0];
    end
    dsec      = now_sec - start_sec - {{(SEC_W-1){1'b0}}, du_raw[USEC_W]};
    divisor   = (gap_usec == '0) ? CFG_W'(1) : gap_usec;
    need      = product + {{(CNT_W-USEC_W){1'b0}}, quotient};
    hold_full = {9'd0, cfg_wdata} * {{(HOLD_W){1'b0}}, HOLD_SECONDS};
  end

  assign md_start      = (state == ST_SETUP) && started;
  assign s_axis_tready = (state == ST_IDLE);

  prl_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .dsec     (dsec),
    .rate     (rate),
    .du       (du),
    .divisor  (divisor),
    .done     (md_done),
    .product  (product),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= RESET_RATE;
      gap_usec   <= RESET_GAP;
      hold_limit <= HOLD_W'(RESET_RATE * HOLD_SECONDS);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RATE: begin
          rate       <= cfg_wdata;
          hold_limit <= hold_full[HOLD_W-1:0];
        end
        REG_GAP:  gap_usec <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      now_sec        <= s_axis_tdata[SEC_W-1:0];
      now_usec       <= s_axis_tdata[SEC_W+USEC_W-1:SEC_W];
      upstream_ready <= s_axis_tdata[SEC_W+USEC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      started       <= 1'b0;
      start_sec     <= '0;
      start_usec    <= '0;
      granted_total <= '0;
      granted       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (started) begin
            state <= ST_RUN;
          end else begin
            started    <= 1'b1;
            start_sec  <= now_sec;
            start_usec <= now_usec;
            granted    <= 1'b0;
            state      <= ST_DONE;
          end
        end
        ST_RUN: begin
          if (md_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (need > granted_total) begin
            granted_total <= granted_total + 1'b1;
            granted       <= 1'b1;
          end else begin
            granted <= 1'b0;
            if (granted_total > {{(CNT_W-HOLD_W){1'b0}}, hold_limit}) begin
              granted_total <= '0;
              start_sec     <= now_sec;
              start_usec    <= now_usec;
            end
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{(OUT_TDATA_W-2){1'b0}}, granted & upstream_ready, granted};
    end
  end

endmodule

[sv/prl_muldiv.sv]
`timescale 1ns / 1ps
// Bit-serial unit: elapsed seconds times rate (shift-add) and elapsed
// microseconds over the gap (restoring divide), one bit of each per cycle.
// Depends on prl_pkg.
module prl_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [prl_pkg::SEC_W-1:0]  dsec,
  input  logic [prl_pkg::CFG_W-1:0]  rate,
  input  logic [prl_pkg::USEC_W-1:0] du,
  input  logic [prl_pkg::CFG_W-1:0]  divisor,
  output logic                       done,
  output logic [prl_pkg::CNT_W-1:0]  product,
  output logic [prl_pkg::USEC_W-1:0] quotient
);
  import prl_pkg::*;

  localparam int STEP_BITS = $clog2(STEPS);

  logic                 busy;
  logic [STEP_BITS-1:0] cnt;
  logic [USEC_W-1:0]    rem;
  logic [USEC_W-1:0]    qsh;
  logic [CFG_W-1:0]     dvs;
  logic [CNT_W-1:0]     acc;
  logic [CNT_W-1:0]     mcand;
  logic [CFG_W-1:0]     mplier;

  logic [USEC_W:0]      trial;
  logic                 ge;
  logic [USEC_W:0]      diff;
  logic [USEC_W-1:0]    rem_next;

  always_comb begin
    trial    = {rem, qsh[USEC_W-1]};
    ge       = trial >= {1'b0, dvs};
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[USEC_W-1:0] : trial[USEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_BITS'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      qsh    <= du;
      dvs    <= divisor;
      acc    <= '0;
      mcand  <= dsec;
      mplier <= rate;
    end else if (busy) begin
      rem    <= rem_next;
      qsh    <= {qsh[USEC_W-2:0], ge};
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[CNT_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[CFG_W-1:1]};
    end
  end

  assign product  = acc;
  assign quotient = qsh;

endmodule

[sv/prl_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for packet_rate_limiter, attached by the bind below.
// Depends on prl_pkg.
module prl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [prl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import prl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_pass_needs_grant: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("packet passed without a granted pull");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:2] == '0)
    else $error("output pad bits set");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while a request is in work");

endmodule

bind packet_rate_limiter prl_checker u_prl_checker (.*);
